// File: rtl/core/hcbp_pkg.sv
// Package for the Huffman code bit packer: field widths, command codes,
// sequencer states and the request/response structs of the merge unit.
// Depends on nothing; every other file of the block imports it.
package hcbp_pkg;

  localparam int CMD_W  = 2;
  localparam int SYM_W  = 5;
  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 3;
  localparam int PEND_W = 7;
  localparam int TAKE_W = 4;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_PACK,
    ST_FLUSH
  } hcbp_state_t;

  typedef struct packed {
    logic [PEND_W-1:0] pend;
    logic [CNT_W-1:0]  cnt;
    logic [LEN_W-1:0]  rem;
    logic              zero_fill;
  } merge_req_t;

  typedef struct packed {
    logic [PEND_W-1:0] pend;
    logic [CNT_W-1:0]  cnt;
    logic [LEN_W-1:0]  rem;
    logic              emit;
    logic [BYTE_W-1:0] byte_val;
    logic              last;
  } merge_rsp_t;

endpackage

// File: rtl/core/hcbp_code_table.sv
// Code table of the Huffman code bit packer: one memory holding each
// symbol's code word and code length, with a registered read port.
// Depends on hcbp_pkg.
module hcbp_code_table import hcbp_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [CODE_W-1:0] wr_code,
  input  logic [LEN_W-1:0]  wr_len,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [CODE_W-1:0] rd_code,
  output logic [LEN_W-1:0]  rd_len
);

  logic [LEN_W+CODE_W-1:0] mem [DEPTH];
  logic [LEN_W+CODE_W-1:0] rd_word_r;

  // Entries have no reset; they are defined once loaded.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_len, wr_code};
    end
    if (rd_en) begin
      rd_word_r <= mem[rd_addr];
    end
  end

  assign rd_code = rd_word_r[CODE_W-1:0];
  assign rd_len  = rd_word_r[LEN_W+CODE_W-1:CODE_W];

endmodule

// File: rtl/core/hcbp_merge.sv
// Shared merge unit of the Huffman code bit packer: moves up to one byte's
// worth of code bits (or zero padding) into the pending partial byte.
// Depends on hcbp_pkg.
module hcbp_merge import hcbp_pkg::*; (
  input  merge_req_t        req,
  input  logic [CODE_W-1:0] code,
  output merge_rsp_t        rsp
);

  logic [TAKE_W-1:0] free_bits;
  logic [TAKE_W-1:0] take;
  logic [LEN_W-1:0]  shamt;
  logic [CODE_W-1:0] code_shift;
  logic [BYTE_W:0]   mask_x;
  logic [BYTE_W-1:0] chunk;
  logic [14:0]       merged;
  logic [TAKE_W-1:0] cnt_sum;
  logic [LEN_W-1:0]  rem_new;

  always_comb begin
    free_bits = TAKE_W'(BYTE_W) - {1'b0, req.cnt};
    if (!req.zero_fill && (req.rem < LEN_W'(free_bits))) begin
      take = req.rem[TAKE_W-1:0];
    end else begin
      take = free_bits;
    end

    // The next code bits sit just below the remaining count.
    shamt      = req.rem - LEN_W'(take);
    code_shift = code >> shamt;
    mask_x     = (9'd1 << take) - 9'd1;
    chunk      = req.zero_fill ? '0 : (code_shift[BYTE_W-1:0] & mask_x[BYTE_W-1:0]);

    merged  = (15'(req.pend) << take) | 15'(chunk);
    cnt_sum = {1'b0, req.cnt} + take;
    rem_new = req.zero_fill ? req.rem : (req.rem - LEN_W'(take));

    rsp.emit     = cnt_sum[CNT_W];
    rsp.byte_val = merged[BYTE_W-1:0];
    rsp.pend     = rsp.emit ? '0 : merged[PEND_W-1:0];
    rsp.cnt      = rsp.emit ? '0 : cnt_sum[CNT_W-1:0];
    rsp.rem      = rem_new;
    // After a full byte the pending bits are empty, so another byte of this
    // item follows only if at least a byte of code remains.
    rsp.last     = req.zero_fill || (rem_new < LEN_W'(BYTE_W));
  end

endmodule

// File: rtl/core/huffman_code_bit_packer.sv
// Top level of the Huffman code bit packer: sequencer, pending byte state
// and output register around the code table and the shared merge unit.
// Depends on hcbp_pkg, hcbp_code_table and hcbp_merge.
//
//   Channel   Direction   Ports                                        Beat
//   input     in          in_valid, in_stall, in_cmd, in_symbol,       one command
//                         in_code_bits, in_code_len
//   result    out         out_valid, out_stall, out_byte, out_last     one packed byte
//
// An encode beat reads the table and then runs merge steps; each merge
// step moves at most one byte's worth of code bits, so a code of n bits on
// top of c pending bits takes about ceil((n + c) / 8) steps (at most 5 for a
// 32-bit code). A flush with pending bits pads them in one merge step.
// Reset is synchronous and active low; it clears the sequencer, the pending
// byte and the output valid. The code table is not cleared.
// A stalled output byte holds the merge unit until the byte is taken.
module huffman_code_bit_packer import hcbp_pkg::*; #(
  parameter int ALPHABET_SIZE = 32,
  parameter int MAX_CODE_LEN  = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic [CODE_W-1:0] in_code_bits,
  input  logic [LEN_W-1:0]  in_code_len,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last
);

  localparam int AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  // Wide enough to compare a symbol against the largest alphabet size.
  localparam int SYM_EXT_W = 9;
  localparam logic [LEN_W:0] MAX_LEN_X = (LEN_W + 1)'(MAX_CODE_LEN);

  hcbp_state_t       state_r, state_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;

  logic                 in_accept;
  logic [SYM_EXT_W-1:0] sym_ext;
  logic                 sym_in_range;
  logic [AW-1:0]        tbl_addr;
  logic [LEN_W-1:0]     len_sat;
  logic                 tbl_wr_en;
  logic                 tbl_rd_en;
  logic [CODE_W-1:0]    tbl_code;
  logic [LEN_W-1:0]     tbl_len;
  logic                 slot_free;
  logic                 step;
  merge_req_t           mreq;
  merge_rsp_t           mrsp;

  // The block takes a new command only while the sequencer is idle.
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign sym_ext      = SYM_EXT_W'(in_symbol);
  assign sym_in_range = (sym_ext < SYM_EXT_W'(ALPHABET_SIZE));
  assign tbl_addr     = sym_ext[AW-1:0];

  // Lengths above the longest supported code are clipped on load.
  assign len_sat = ({1'b0, in_code_len} > MAX_LEN_X) ? MAX_LEN_X[LEN_W-1:0] : in_code_len;

  assign tbl_wr_en = in_accept && (in_cmd == CMD_LOAD) && sym_in_range;
  assign tbl_rd_en = in_accept && (in_cmd == CMD_ENCODE) && sym_in_range;

  hcbp_code_table #(
    .DEPTH (ALPHABET_SIZE),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_addr),
    .wr_code (in_code_bits),
    .wr_len  (len_sat),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_addr),
    .rd_code (tbl_code),
    .rd_len  (tbl_len)
  );

  // The read data holds until the next encode, so the merge unit works
  // straight from the table's output register.
  hcbp_merge u_merge (
    .req  (mreq),
    .code (tbl_code),
    .rsp  (mrsp)
  );

  // A step may only run when its byte, if any, has a free output register.
  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    pend_nxt       = pend_r;
    cnt_nxt        = cnt_r;
    rem_nxt        = rem_r;
    step           = 1'b0;
    mreq.pend      = pend_r;
    mreq.cnt       = cnt_r;
    mreq.rem       = rem_r;
    mreq.zero_fill = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (tbl_rd_en) begin
          state_nxt = ST_FETCH;
        end else if (in_accept && (in_cmd == CMD_FLUSH) && (cnt_r != '0)) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FETCH: begin
        // An empty code appends nothing.
        rem_nxt   = tbl_len;
        state_nxt = (tbl_len == '0) ? ST_IDLE : ST_PACK;
      end
      ST_PACK: begin
        if (slot_free) begin
          step     = 1'b1;
          pend_nxt = mrsp.pend;
          cnt_nxt  = mrsp.cnt;
          rem_nxt  = mrsp.rem;
          if (mrsp.rem == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        // Padding with zeros always completes the byte in one step.
        mreq.zero_fill = 1'b1;
        if (slot_free) begin
          step      = 1'b1;
          pend_nxt  = mrsp.pend;
          cnt_nxt   = mrsp.cnt;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && mrsp.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && mrsp.emit) begin
      out_byte_r <= mrsp.byte_val;
      out_last_r <= mrsp.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  // The flush state is entered only with pending bits to pad.
  a_flush_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) |-> (cnt_r != '0))
    else $error("flush state entered without pending bits");

  // Packing never runs with no code bits left.
  a_pack_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PACK) |-> (rem_r != '0))
    else $error("packing with no remaining code bits");

  // A byte that is not the last of its command means more bytes are coming.
  a_not_last_more: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (state_r == ST_PACK))
    else $error("non-final byte pending while the sequencer is not packing");

endmodule

// File: sim/huffman_code_bit_packer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for huffman_code_bit_packer: loads code table entries,
// encodes symbols and flushes, then checks every packed byte against a predictor.
// Depends on hcbp_pkg and the huffman_code_bit_packer RTL.
module huffman_code_bit_packer_test;
  import hcbp_pkg::*;

  // These match the parameter defaults of the block under test.
  localparam int ALPHABET = 32;
  localparam int MAX_CODE_LEN = 32;

  // Command code 3 has no name in the package. The block must ignore it.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // The directed pass and the pressure burst send 36 beats; the random beats
  // bring the run to about 110 command beats.
  localparam int RANDOM_ITEMS = 74;
  localparam int PRESSURE_BEATS = 14;
  localparam int PRESSURE_HOLD = 80;
  // Waiting this long after the last expected byte leaves room for a stray
  // extra byte to show up.
  localparam int DRAIN_CYCLES = 24;

  // One packed byte as it is expected on the result channel.
  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              last;
  } packed_byte_t;

  // The tracker keeps its own copy of the code table and of the partial byte.
  // For every accepted command beat it works out the bytes that the block
  // must emit, and it matches them in order against the bytes that arrive.
  class packed_byte_tracker;
    logic [CODE_W-1:0] code_word [ALPHABET];
    logic [LEN_W-1:0]  code_length [ALPHABET];
    logic [BYTE_W-1:0] fill_bits;
    int unsigned       fill_count;
    packed_byte_t      expected_bytes [$];
    int unsigned       mismatches;

    function new();
      fill_bits = '0;
      fill_count = 0;
      mismatches = 0;
    endfunction

    function void absorb_command(logic [CMD_W-1:0] cmd, logic [SYM_W-1:0] sym,
                                 logic [CODE_W-1:0] bits, logic [LEN_W-1:0] len);
      int unsigned total;
      int unsigned made;
      logic [BYTE_W-1:0] padded;
      made = 0;
      case (cmd)
        CMD_LOAD: begin
          // A length above the longest code is clipped to the longest code.
          code_word[sym] = bits;
          code_length[sym] = (len > MAX_CODE_LEN) ? LEN_W'(MAX_CODE_LEN) : len;
        end
        CMD_ENCODE: begin
          // The last byte that this beat completes carries the last flag.
          total = (fill_count + code_length[sym]) / BYTE_W;
          for (int i = code_length[sym]; i > 0; i--) begin
            fill_bits = {fill_bits[BYTE_W-2:0], code_word[sym][i-1]};
            fill_count++;
            if (fill_count == BYTE_W) begin
              made++;
              expected_bytes.push_back('{value: fill_bits, last: (made == total)});
              fill_bits = '0;
              fill_count = 0;
            end
          end
        end
        CMD_FLUSH: begin
          // An empty flush emits nothing at all.
          if (fill_count != 0) begin
            padded = fill_bits << (BYTE_W - fill_count);
            expected_bytes.push_back('{value: padded, last: 1'b1});
            fill_bits = '0;
            fill_count = 0;
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_byte(logic [BYTE_W-1:0] value, logic last);
      packed_byte_t want;
      if (expected_bytes.size() == 0) begin
        $error("unexpected beat: out_byte=%02h out_last=%0b", value, last);
        mismatches++;
        return;
      end
      want = expected_bytes.pop_front();
      if (value !== want.value) begin
        $error("out_byte: expected %02h, actual %02h", want.value, value);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("out_last: expected %0b, actual %0b", want.last, last);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_bytes.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [CMD_W-1:0]  in_cmd;
  logic [SYM_W-1:0]  in_symbol;
  logic [CODE_W-1:0] in_code_bits;
  logic [LEN_W-1:0]  in_code_len;
  logic              out_valid;
  logic              out_stall;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;

  packed_byte_tracker tracker = new();

  // Table entries that have been loaded so far. Encoding an entry that was
  // never loaded is outside the contract, so the stimulus never does it.
  bit loaded [ALPHABET];
  int unsigned random_items;
  int send_calm;
  int recv_calm;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_request;

  always #6 clk = ~clk;

  huffman_code_bit_packer dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_symbol    (in_symbol),
    .in_code_bits (in_code_bits),
    .in_code_len  (in_code_len),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_last     (out_last)
  );

  // Idle gaps for either side: mostly none, often a short one, now and
  // then a long one. Once in a while a calm stretch of back-to-back cycles starts.
  function automatic int pick_gap(inout int calm_left);
    int roll;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      calm_left = $urandom_range(10, 30);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Code lengths lean toward short codes but reach zero, the longest code and
  // the clipped range above it.
  function automatic logic [LEN_W-1:0] pick_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return '0;
    if (roll < 60) return LEN_W'($urandom_range(1, 8));
    if (roll < 80) return LEN_W'($urandom_range(9, 20));
    if (roll < 92) return LEN_W'($urandom_range(21, MAX_CODE_LEN));
    return LEN_W'($urandom_range(MAX_CODE_LEN + 1, 63));
  endfunction

  function automatic logic [SYM_W-1:0] pick_loaded();
    logic [SYM_W-1:0] sym;
    do sym = SYM_W'($urandom_range(0, ALPHABET - 1)); while (!loaded[sym]);
    return sym;
  endfunction

  // Offers one command beat and returns at the rising edge where it is taken.
  // Inputs change only at falling edges, and each falling edge sees at most one
  // assignment to in_valid. An eager beat is offered with no idle gap.
  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym,
                           input logic [CODE_W-1:0] bits, input logic [LEN_W-1:0] len,
                           input bit eager);
    int gap;
    gap = eager ? 0 : pick_gap(send_calm);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_symbol <= sym;
    in_code_bits <= bits;
    in_code_len <= len;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.absorb_command(cmd, sym, bits, len);
    if (cmd == CMD_LOAD) loaded[sym] = 1'b1;
  endtask

  task automatic send_random_beat();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      send_beat(CMD_LOAD, SYM_W'($urandom_range(0, ALPHABET - 1)), $urandom, pick_len(),
                1'b0);
    end else if (roll < 80) begin
      send_beat(CMD_ENCODE, pick_loaded(), $urandom, LEN_W'($urandom), 1'b0);
    end else if (roll < 92) begin
      send_beat(CMD_FLUSH, SYM_W'($urandom), $urandom, LEN_W'($urandom), 1'b0);
    end else begin
      // Noise: the unused command must leave the state alone.
      send_beat(CMD_UNUSED, SYM_W'($urandom), $urandom, LEN_W'($urandom), 1'b0);
    end
    random_items++;
  endtask

  // Result side. The receiver stalls in random gaps and, once asked, holds off
  // for a long stretch so that the block backs up and stalls its input.
  initial begin
    int hold_left;
    int gap;
    out_stall = 1'b0;
    hold_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = PRESSURE_HOLD;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        gap = pick_gap(recv_calm);
        out_stall <= (gap > 0);
        hold_left = (gap > 0) ? gap - 1 : 0;
      end
    end
  end

  // Every byte taken at a rising edge is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      tracker.check_byte(out_byte, out_last);
    end
  end

  // Stimulus: reset, a directed pass over the special cases, a burst that
  // fills the block against a held-off receiver, then random beats.
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_LOAD;
    in_symbol = '0;
    in_code_bits = '0;
    in_code_len = '0;
    random_items = 0;
    send_calm = 0;
    recv_calm = 0;
    hold_request = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Table entries at the extremes of symbol, code word and code length.
    send_beat(CMD_LOAD, 5'd0, 32'hFFFF_FFFF, 6'd32, 1'b0);
    send_beat(CMD_LOAD, 5'd31, 32'h0000_0000, 6'd1, 1'b0);
    send_beat(CMD_LOAD, 5'd1, 32'h0000_0005, 6'd3, 1'b0);
    // Lengths above the longest code are clipped on load.
    send_beat(CMD_LOAD, 5'd2, 32'hDEAD_BEEF, 6'd63, 1'b0);
    send_beat(CMD_LOAD, 5'd4, 32'h0000_0001, 6'd33, 1'b0);
    // A zero-length code appends nothing when encoded.
    send_beat(CMD_LOAD, 5'd3, 32'hAAAA_AAAA, 6'd0, 1'b0);
    // Flush with nothing pending gives no byte.
    send_beat(CMD_FLUSH, 5'd0, 32'h0000_0000, 6'd0, 1'b0);
    // A full 32-bit code on an empty byte gives four bytes.
    send_beat(CMD_ENCODE, 5'd0, 32'h0000_0000, 6'd0, 1'b0);
    send_beat(CMD_ENCODE, 5'd31, 32'h0000_0000, 6'd0, 1'b0);
    send_beat(CMD_ENCODE, 5'd3, 32'h0000_0000, 6'd0, 1'b0);
    send_beat(CMD_UNUSED, 5'd31, 32'hFFFF_FFFF, 6'd63, 1'b0);
    send_beat(CMD_ENCODE, 5'd1, 32'hFFFF_FFFF, 6'd63, 1'b0);
    // Partial byte padded with zeros in its low bits.
    send_beat(CMD_FLUSH, 5'd31, 32'hFFFF_FFFF, 6'd63, 1'b0);
    send_beat(CMD_ENCODE, 5'd2, 32'h0000_0000, 6'd0, 1'b0);
    send_beat(CMD_ENCODE, 5'd4, 32'h0000_0000, 6'd0, 1'b0);
    // One pending bit plus a 32-bit code needs the most merge steps.
    send_beat(CMD_ENCODE, 5'd31, 32'h0000_0000, 6'd0, 1'b0);
    send_beat(CMD_ENCODE, 5'd0, 32'h0000_0000, 6'd0, 1'b0);
    send_beat(CMD_FLUSH, 5'd0, 32'h0000_0000, 6'd0, 1'b0);
    // Seven pending bits, then one more bit completes exactly one byte.
    send_beat(CMD_LOAD, 5'd16, 32'h0000_007F, 6'd7, 1'b0);
    send_beat(CMD_ENCODE, 5'd16, 32'h0000_0000, 6'd0, 1'b0);
    send_beat(CMD_ENCODE, 5'd31, 32'h0000_0000, 6'd0, 1'b0);
    send_beat(CMD_FLUSH, 5'd0, 32'h0000_0000, 6'd0, 1'b0);

    // Back-to-back encodes while the receiver holds off: the output register
    // and the merge unit fill, and in_stall must hold the offered beat.
    hold_request = 1'b1;
    repeat (PRESSURE_BEATS) begin
      send_beat(CMD_ENCODE, pick_loaded(), $urandom, LEN_W'($urandom), 1'b1);
    end

    while (random_items < RANDOM_ITEMS) begin
      send_random_beat();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
